// ===== rtl/core/fble_pkg.sv =====
`default_nettype none

package fble_pkg;

   // field widths
   localparam int TIME_W     = 48;
   localparam int GAP_W      = TIME_W + 1;
   localparam int DUR_W      = 40;
   localparam int SIZE_W     = 40;
   localparam int RATIO_W    = 16;
   localparam int CHAR_W     = 7;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 48;

   // shared divider: for the ratio, the dividend is a gap shifted left by 8 fraction bits
   localparam int FRAC_W  = 8;
   localparam int DQ_W    = TIME_W + FRAC_W;
   localparam int CNT_W   = $clog2(DQ_W);
   localparam int ZQ_W    = 6;

   localparam int MAX_IDLE_ZEROS_DEF = 62;

   // ratio used when the smaller gap is not positive
   localparam logic [DQ_W-1:0] RATIO_ONE = DQ_W'(256);

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_PERIOD  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_STRONG = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_WEAK   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_NOTPER = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DUR_SHORT    = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DUR_LONG     = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_SMALL   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_LARGE   = 4'd7;

   // configuration reset values
   localparam logic [TIME_W-1:0]  IDLE_PERIOD_RST  = 48'd3600000000;
   localparam logic [RATIO_W-1:0] RATIO_STRONG_RST = 16'd269;
   localparam logic [RATIO_W-1:0] RATIO_WEAK_RST   = 16'd333;
   localparam logic [RATIO_W-1:0] RATIO_NOTPER_RST = 16'd1280;
   localparam logic [DUR_W-1:0]   DUR_SHORT_RST    = 40'd100000;
   localparam logic [DUR_W-1:0]   DUR_LONG_RST     = 40'd10000000;
   localparam logic [SIZE_W-1:0]  SIZE_SMALL_RST   = 40'd250;
   localparam logic [SIZE_W-1:0]  SIZE_LARGE_RST   = 40'd1100;

   // gap symbol limits, inclusive
   localparam logic [GAP_W-1:0] GAP_DOT_US   = 49'd5000000;
   localparam logic [GAP_W-1:0] GAP_COMMA_US = 49'd60000000;
   localparam logic [GAP_W-1:0] GAP_PLUS_US  = 49'd300000000;
   localparam logic [GAP_W-1:0] GAP_STAR_US  = 49'd3600000000;

   // symbols
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 7'h2E;
   localparam logic [CHAR_W-1:0] CHAR_COMMA = 7'h2C;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;
   localparam logic [CHAR_W-1:0] CHAR_STAR  = 7'h2A;
   localparam logic [CHAR_W-1:0] CHAR_ONE   = 7'h31;
   localparam logic [CHAR_W-1:0] CHAR_LC_A  = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_UC_A  = 7'h41;
   localparam logic [CHAR_W-1:0] CHAR_LC_R  = 7'h72;
   localparam logic [CHAR_W-1:0] CHAR_UC_R  = 7'h52;

   typedef enum logic [2:0] {
      PER_NONE,
      PER_STRONG,
      PER_WEAK,
      PER_WEAK_NOT,
      PER_NOT
   } per_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_ZCHK,
      ST_ZDIV,
      ST_ZSAT,
      ST_RSETUP,
      ST_RDIV,
      ST_CLASS,
      ST_EZERO,
      ST_ELET,
      ST_EGAP
   } state_type;

   // divider control from the sequencer
   typedef struct packed {
      logic load;
      logic step;
      logic shift;
   } div_cmd_type;

   // small / medium / large class of a value against two limits
   function automatic logic [1:0] class3(input logic [DUR_W-1:0] v,
                                         input logic [DUR_W-1:0] lo,
                                         input logic [DUR_W-1:0] hi);
      logic [1:0] c;
      if (v <= lo) begin
         c = 2'd0;
      end else if (v <= hi) begin
         c = 2'd1;
      end else begin
         c = 2'd2;
      end
      return c;
   endfunction

   // letter from periodicity row and size*3 + duration column
   function automatic logic [CHAR_W-1:0] letter_char(input per_type per,
                                                     input logic [1:0] sz,
                                                     input logic [1:0] du);
      logic [3:0]        idx;
      logic [CHAR_W-1:0] base;
      idx = ({2'b00, sz} * 4'd3) + {2'b00, du};
      case (per)
         PER_STRONG:   base = CHAR_LC_A;
         PER_WEAK:     base = CHAR_UC_A;
         PER_WEAK_NOT: base = CHAR_LC_R;
         PER_NOT:      base = CHAR_UC_R;
         default:      base = CHAR_ONE;
      endcase
      return base + {3'b000, idx};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fble_req_if.sv =====
`default_nettype none

interface fble_req_if;
   logic                          valid;
   logic                          ready;
   logic [fble_pkg::TIME_W-1:0]   start_time_us;
   logic [fble_pkg::DUR_W-1:0]    duration_us;
   logic [fble_pkg::SIZE_W-1:0]   size_bytes;

   modport source (output valid, output start_time_us, output duration_us,
                   output size_bytes, input ready);
   modport sink   (input valid, input start_time_us, input duration_us,
                   input size_bytes, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fble_rsp_if.sv =====
`default_nettype none

interface fble_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fble_pkg::CHAR_W-1:0]   symbol_char;
   logic                          last_symbol;

   modport source (output valid, output symbol_char, output last_symbol, input ready);
   modport sink   (input valid, input symbol_char, input last_symbol, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fble_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per step; quotient shifts into dq
module fble_div (
   input  wire                              clock,
   input  fble_pkg::div_cmd_type            cmd,
   input  wire [fble_pkg::TIME_W-1:0]       rem_init,
   input  wire [fble_pkg::DQ_W-1:0]         dq_init,
   input  wire [fble_pkg::TIME_W-1:0]       dvs_init,
   output logic [fble_pkg::DQ_W-1:0]        dq,
   output logic                             ge
);

   logic [fble_pkg::TIME_W-1:0] rem_ff, rem_in;
   logic [fble_pkg::DQ_W-1:0]   dq_ff, dq_in;
   logic [fble_pkg::TIME_W-1:0] dvs_ff, dvs_in;
   logic [fble_pkg::TIME_W:0]   opa;
   logic [fble_pkg::TIME_W+1:0] diff;

   // partial remainder, with or without the next dividend bit
   assign opa  = cmd.shift ? {rem_ff, dq_ff[fble_pkg::DQ_W-1]} : {1'b0, rem_ff};
   assign diff = {1'b0, opa} - {2'b00, dvs_ff};
   assign ge   = ~diff[fble_pkg::TIME_W+1];
   assign dq   = dq_ff;

   // load or step
   always_comb begin
      rem_in = rem_ff;
      dq_in  = dq_ff;
      dvs_in = dvs_ff;
      if (cmd.load) begin
         rem_in = rem_init;
         dq_in  = dq_init;
         dvs_in = dvs_init;
      end else if (cmd.step) begin
         rem_in = ge ? diff[fble_pkg::TIME_W-1:0] : opa[fble_pkg::TIME_W-1:0];
         dq_in  = {dq_ff[fble_pkg::DQ_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      dvs_ff <= dvs_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/flow_behaviour_letter_encoder.sv =====
`default_nettype none

// channel   dir   transfer                         fields
// req_ch    in    valid & ready                    start_time_us, duration_us, size_bytes
// rsp_ch    out   valid & ready                    symbol_char, last_symbol
// csr       in    csr_we (no handshake)            csr_index, csr_wdata
//
// One flow at a time. After the transfer in: the setup state, the idle-zero count
// (ZCHK, ZDIV, ZSAT) when a zero run is possible, the gap ratio (RSETUP, RDIV)
// when both gaps are valid (56-step divider, one quotient bit per cycle), the
// class state, then one symbol per cycle while the output is not stalled.
// Synchronous reset restores the register defaults and forgets the previous flow.
// A stalled result holds in the output register; the next flow may enter then.

module flow_behaviour_letter_encoder #(
   parameter int MAX_IDLE_ZEROS = fble_pkg::MAX_IDLE_ZEROS_DEF
) (
   input  wire                                  clock,
   input  wire                                  reset,
   fble_req_if.sink                             req_ch,
   fble_rsp_if.source                           rsp_ch,
   input  wire                                  csr_we,
   input  wire [fble_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire [fble_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int TW = fble_pkg::TIME_W;
   localparam int GW = fble_pkg::GAP_W;

   // configuration registers
   logic [TW-1:0]                    idle_period_ff;
   logic [fble_pkg::RATIO_W-1:0]     ratio_strong_ff, ratio_weak_ff, ratio_notper_ff;
   logic [fble_pkg::DUR_W-1:0]       dur_short_ff, dur_long_ff;
   logic [fble_pkg::SIZE_W-1:0]      size_small_ff, size_large_ff;

   // flow history
   logic [TW-1:0]                    prev_start_ff, prev_start_in;
   logic                             have_prev_ff, have_prev_in;
   logic [GW-1:0]                    prev_gap_ff, prev_gap_in;
   logic                             prev_gap_valid_ff, prev_gap_valid_in;

   // working registers for the flow in progress
   fble_pkg::state_type              state_ff, state_in;
   logic [fble_pkg::DUR_W-1:0]       dur_ff, dur_in;
   logic [fble_pkg::SIZE_W-1:0]      size_ff, size_in;
   logic [GW-1:0]                    gap_cur_ff, gap_cur_in;
   logic [GW-1:0]                    gap_old_ff, gap_old_in;
   logic                             cur_v_ff, cur_v_in;
   logic                             both_v_ff, both_v_in;
   logic [fble_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [fble_pkg::ZQ_W-1:0]        zeros_ff, zeros_in;
   logic [fble_pkg::CHAR_W-1:0]      letter_ff, letter_in;
   logic [fble_pkg::CHAR_W-1:0]      gsym_ff, gsym_in;
   logic                             gsym_v_ff, gsym_v_in;

   // output register
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [fble_pkg::CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                             rsp_last_ff, rsp_last_in;

   // sequencer outputs
   fble_pkg::div_cmd_type            div_cmd;
   logic                             emit_en;
   logic [fble_pkg::CHAR_W-1:0]      emit_char;
   logic                             emit_last;

   // divider hookup
   logic [TW-1:0]                    div_rem_init, div_dvs_init;
   logic [fble_pkg::DQ_W-1:0]        div_dq_init, div_dq;
   logic                             div_ge;

   // helpers
   logic                             req_fire, out_free;
   logic [GW-1:0]                    gap_new;
   logic                             sel_cur, sel_old, zero_go;
   logic [TW-1:0]                    zero_src;
   logic                             cur_ge_old, small_pos;
   logic [GW-1:0]                    gap_big, gap_small;
   logic [fble_pkg::ZQ_W-1:0]        zq, zmax;
   logic                             ratio_hi;
   logic [fble_pkg::RATIO_W-1:0]     ratio_lo;
   fble_pkg::per_type                per;
   logic [1:0]                       sz_cls, du_cls;

   assign req_fire      = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == fble_pkg::ST_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.symbol_char = rsp_char_ff;
   assign rsp_ch.last_symbol = rsp_last_ff;

   // current gap, zero when there is no previous flow
   assign gap_new = have_prev_ff ?
                    ({1'b0, req_ch.start_time_us} - {1'b0, prev_start_ff}) : '0;

   // which gap feeds the idle-zero count
   assign sel_cur  = !gap_cur_ff[GW-1] && (gap_cur_ff[TW-1:0] >= idle_period_ff);
   assign sel_old  = !gap_old_ff[GW-1] && (gap_old_ff[TW-1:0] >= idle_period_ff);
   assign zero_go  = both_v_ff && (sel_cur || sel_old);
   assign zero_src = sel_cur ? gap_cur_ff[TW-1:0] : gap_old_ff[TW-1:0];

   // larger and smaller gap for the ratio
   assign cur_ge_old = ($signed(gap_cur_ff) >= $signed(gap_old_ff));
   assign gap_big    = cur_ge_old ? gap_cur_ff : gap_old_ff;
   assign gap_small  = cur_ge_old ? gap_old_ff : gap_cur_ff;
   assign small_pos  = !gap_small[GW-1] && (gap_small[TW-1:0] != '0);

   // zero count saturation
   assign zq   = div_dq[fble_pkg::ZQ_W-1:0];
   assign zmax = fble_pkg::ZQ_W'(MAX_IDLE_ZEROS);

   // periodicity and letter classes
   assign ratio_hi = |div_dq[fble_pkg::DQ_W-1:fble_pkg::RATIO_W];
   assign ratio_lo = div_dq[fble_pkg::RATIO_W-1:0];
   assign sz_cls   = fble_pkg::class3(size_ff, size_small_ff, size_large_ff);
   assign du_cls   = fble_pkg::class3(dur_ff, dur_short_ff, dur_long_ff);

   always_comb begin
      if (!both_v_ff) begin
         per = fble_pkg::PER_NONE;
      end else if (!ratio_hi && (ratio_lo <= ratio_strong_ff)) begin
         per = fble_pkg::PER_STRONG;
      end else if (!ratio_hi && (ratio_lo < ratio_weak_ff)) begin
         per = fble_pkg::PER_WEAK;
      end else if (!ratio_hi && (ratio_lo < ratio_notper_ff)) begin
         per = fble_pkg::PER_WEAK_NOT;
      end else begin
         per = fble_pkg::PER_NOT;
      end
   end

   // divider load values per phase
   always_comb begin
      if (state_ff == fble_pkg::ST_SETUP) begin
         div_rem_init = {{fble_pkg::ZQ_W{1'b0}}, zero_src[TW-1:fble_pkg::ZQ_W]};
         div_dq_init  = {zero_src[fble_pkg::ZQ_W-1:0],
                         {(fble_pkg::DQ_W-fble_pkg::ZQ_W){1'b0}}};
         div_dvs_init = idle_period_ff;
      end else begin
         div_rem_init = '0;
         div_dq_init  = small_pos ? {gap_big[TW-1:0], {fble_pkg::FRAC_W{1'b0}}}
                                  : fble_pkg::RATIO_ONE;
         div_dvs_init = gap_small[TW-1:0];
      end
   end

   fble_div u_div (
      .clock    (clock),
      .cmd      (div_cmd),
      .rem_init (div_rem_init),
      .dq_init  (div_dq_init),
      .dvs_init (div_dvs_init),
      .dq       (div_dq),
      .ge       (div_ge)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fble_pkg::ST_IDLE: begin
            if (req_fire) state_in = fble_pkg::ST_SETUP;
         end
         fble_pkg::ST_SETUP: begin
            state_in = zero_go ? fble_pkg::ST_ZCHK : fble_pkg::ST_RSETUP;
         end
         fble_pkg::ST_ZCHK: begin
            state_in = div_ge ? fble_pkg::ST_RSETUP : fble_pkg::ST_ZDIV;
         end
         fble_pkg::ST_ZDIV: begin
            if (cnt_ff == '0) state_in = fble_pkg::ST_ZSAT;
         end
         fble_pkg::ST_ZSAT: begin
            state_in = fble_pkg::ST_RSETUP;
         end
         fble_pkg::ST_RSETUP: begin
            state_in = (both_v_ff && small_pos) ? fble_pkg::ST_RDIV : fble_pkg::ST_CLASS;
         end
         fble_pkg::ST_RDIV: begin
            if (cnt_ff == '0) state_in = fble_pkg::ST_CLASS;
         end
         fble_pkg::ST_CLASS: begin
            state_in = (zeros_ff != '0) ? fble_pkg::ST_EZERO : fble_pkg::ST_ELET;
         end
         fble_pkg::ST_EZERO: begin
            if (out_free && (zeros_ff == fble_pkg::ZQ_W'(1))) state_in = fble_pkg::ST_ELET;
         end
         fble_pkg::ST_ELET: begin
            if (out_free) state_in = gsym_v_ff ? fble_pkg::ST_EGAP : fble_pkg::ST_IDLE;
         end
         fble_pkg::ST_EGAP: begin
            if (out_free) state_in = fble_pkg::ST_IDLE;
         end
         default: state_in = fble_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      div_cmd   = '0;
      emit_en   = 1'b0;
      emit_char = fble_pkg::CHAR_ZERO;
      emit_last = 1'b0;
      case (state_ff)
         fble_pkg::ST_SETUP: begin
            div_cmd.load = zero_go;
         end
         fble_pkg::ST_ZDIV, fble_pkg::ST_RDIV: begin
            div_cmd.step  = 1'b1;
            div_cmd.shift = 1'b1;
         end
         fble_pkg::ST_RSETUP: begin
            div_cmd.load = both_v_ff;
         end
         fble_pkg::ST_EZERO: begin
            emit_en = out_free;
         end
         fble_pkg::ST_ELET: begin
            emit_en   = out_free;
            emit_char = letter_ff;
            emit_last = !gsym_v_ff;
         end
         fble_pkg::ST_EGAP: begin
            emit_en   = out_free;
            emit_char = gsym_ff;
            emit_last = 1'b1;
         end
         default: begin
            div_cmd = '0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      prev_start_in     = prev_start_ff;
      have_prev_in      = have_prev_ff;
      prev_gap_in       = prev_gap_ff;
      prev_gap_valid_in = prev_gap_valid_ff;
      dur_in            = dur_ff;
      size_in           = size_ff;
      gap_cur_in        = gap_cur_ff;
      gap_old_in        = gap_old_ff;
      cur_v_in          = cur_v_ff;
      both_v_in         = both_v_ff;
      cnt_in            = cnt_ff;
      zeros_in          = zeros_ff;
      letter_in         = letter_ff;
      gsym_in           = gsym_ff;
      gsym_v_in         = gsym_v_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_char_in       = rsp_char_ff;
      rsp_last_in       = rsp_last_ff;

      // take the flow and roll the history forward
      if (req_fire) begin
         dur_in            = req_ch.duration_us;
         size_in           = req_ch.size_bytes;
         gap_cur_in        = gap_new;
         gap_old_in        = prev_gap_ff;
         cur_v_in          = have_prev_ff;
         both_v_in         = have_prev_ff && prev_gap_valid_ff;
         prev_start_in     = req_ch.start_time_us;
         have_prev_in      = 1'b1;
         prev_gap_in       = gap_new;
         prev_gap_valid_in = have_prev_ff;
      end

      case (state_ff)
         fble_pkg::ST_SETUP: begin
            zeros_in  = '0;
            gsym_v_in = cur_v_ff && ($signed(gap_cur_ff) <= $signed(fble_pkg::GAP_STAR_US));
            if ($signed(gap_cur_ff) <= $signed(fble_pkg::GAP_DOT_US)) begin
               gsym_in = fble_pkg::CHAR_DOT;
            end else if ($signed(gap_cur_ff) <= $signed(fble_pkg::GAP_COMMA_US)) begin
               gsym_in = fble_pkg::CHAR_COMMA;
            end else if ($signed(gap_cur_ff) <= $signed(fble_pkg::GAP_PLUS_US)) begin
               gsym_in = fble_pkg::CHAR_PLUS;
            end else begin
               gsym_in = fble_pkg::CHAR_STAR;
            end
         end
         fble_pkg::ST_ZCHK: begin
            // quotient of 64 or more saturates at once
            if (div_ge) zeros_in = zmax;
            cnt_in = fble_pkg::CNT_W'(fble_pkg::ZQ_W - 1);
         end
         fble_pkg::ST_ZDIV, fble_pkg::ST_RDIV: begin
            cnt_in = cnt_ff - fble_pkg::CNT_W'(1);
         end
         fble_pkg::ST_ZSAT: begin
            zeros_in = (zq > zmax) ? zmax : zq;
         end
         fble_pkg::ST_RSETUP: begin
            cnt_in = fble_pkg::CNT_W'(fble_pkg::DQ_W - 1);
         end
         fble_pkg::ST_CLASS: begin
            letter_in = fble_pkg::letter_char(per, sz_cls, du_cls);
         end
         fble_pkg::ST_EZERO: begin
            if (out_free) zeros_in = zeros_ff - fble_pkg::ZQ_W'(1);
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase

      // output register
      if (emit_en) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= fble_pkg::ST_IDLE;
         have_prev_ff      <= 1'b0;
         prev_gap_valid_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         have_prev_ff      <= have_prev_in;
         prev_gap_valid_ff <= prev_gap_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prev_start_ff <= prev_start_in;
      prev_gap_ff   <= prev_gap_in;
      dur_ff        <= dur_in;
      size_ff       <= size_in;
      gap_cur_ff    <= gap_cur_in;
      gap_old_ff    <= gap_old_in;
      cur_v_ff      <= cur_v_in;
      both_v_ff     <= both_v_in;
      cnt_ff        <= cnt_in;
      zeros_ff      <= zeros_in;
      letter_ff     <= letter_in;
      gsym_ff       <= gsym_in;
      gsym_v_ff     <= gsym_v_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // configuration writes, unknown indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_period_ff  <= fble_pkg::IDLE_PERIOD_RST;
         ratio_strong_ff <= fble_pkg::RATIO_STRONG_RST;
         ratio_weak_ff   <= fble_pkg::RATIO_WEAK_RST;
         ratio_notper_ff <= fble_pkg::RATIO_NOTPER_RST;
         dur_short_ff    <= fble_pkg::DUR_SHORT_RST;
         dur_long_ff     <= fble_pkg::DUR_LONG_RST;
         size_small_ff   <= fble_pkg::SIZE_SMALL_RST;
         size_large_ff   <= fble_pkg::SIZE_LARGE_RST;
      end else if (csr_we) begin
         case (csr_index)
            fble_pkg::CSR_IDLE_PERIOD:  idle_period_ff  <= csr_wdata[TW-1:0];
            fble_pkg::CSR_RATIO_STRONG: ratio_strong_ff <= csr_wdata[fble_pkg::RATIO_W-1:0];
            fble_pkg::CSR_RATIO_WEAK:   ratio_weak_ff   <= csr_wdata[fble_pkg::RATIO_W-1:0];
            fble_pkg::CSR_RATIO_NOTPER: ratio_notper_ff <= csr_wdata[fble_pkg::RATIO_W-1:0];
            fble_pkg::CSR_DUR_SHORT:    dur_short_ff    <= csr_wdata[fble_pkg::DUR_W-1:0];
            fble_pkg::CSR_DUR_LONG:     dur_long_ff     <= csr_wdata[fble_pkg::DUR_W-1:0];
            fble_pkg::CSR_SIZE_SMALL:   size_small_ff   <= csr_wdata[fble_pkg::SIZE_W-1:0];
            fble_pkg::CSR_SIZE_LARGE:   size_large_ff   <= csr_wdata[fble_pkg::SIZE_W-1:0];
            default: begin
               idle_period_ff <= idle_period_ff;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== tb/flow_behaviour_letter_encoder_tb.sv =====
`default_nettype none

module flow_behaviour_letter_encoder_tb;
   import fble_pkg::*;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int HOLD_OFF_CYCLES = 2000;
   localparam int MAX_ZEROS       = MAX_IDLE_ZEROS_DEF;
   localparam int MAX_REPORTS     = 200;

   // gap symbol limits as signed values, so that negative gaps compare right
   localparam longint DOT_LIMIT   = GAP_DOT_US;
   localparam longint COMMA_LIMIT = GAP_COMMA_US;
   localparam longint PLUS_LIMIT  = GAP_PLUS_US;
   localparam longint STAR_LIMIT  = GAP_STAR_US;

   // first index past the register file, writes there are dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = CSR_SIZE_LARGE + 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0] start_time_us;
      logic [DUR_W-1:0]  duration_us;
      logic [SIZE_W-1:0] size_bytes;
   } flow_t;

   typedef struct packed {
      logic [CHAR_W-1:0] symbol_char;
      logic              last_symbol;
   } symbol_t;

   typedef struct packed {
      logic [TIME_W-1:0]  idle_period_us;
      logic [RATIO_W-1:0] ratio_strong;
      logic [RATIO_W-1:0] ratio_weak;
      logic [RATIO_W-1:0] ratio_not_periodic;
      logic [DUR_W-1:0]   dur_short_us;
      logic [DUR_W-1:0]   dur_long_us;
      logic [SIZE_W-1:0]  size_small_bytes;
      logic [SIZE_W-1:0]  size_large_bytes;
   } enc_cfg_t;

   localparam enc_cfg_t RESET_CFG = '{IDLE_PERIOD_RST, RATIO_STRONG_RST, RATIO_WEAK_RST,
                                      RATIO_NOTPER_RST, DUR_SHORT_RST, DUR_LONG_RST,
                                      SIZE_SMALL_RST, SIZE_LARGE_RST};

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fble_req_if req_ch ();
   fble_rsp_if rsp_ch ();

   flow_behaviour_letter_encoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // encoder state as the testbench sees it
   enc_cfg_t          cfg = RESET_CFG;
   logic [TIME_W-1:0] last_start_us = '0;
   logic              seen_flow = 1'b0;
   longint            last_gap_us = 0;
   logic              last_gap_ok = 1'b0;

   symbol_t expected_symbols[$];

   int error_count    = 0;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;

   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[flow_behaviour_letter_encoder] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // symbol prediction
   // ---------------------------------------------------------------

   // whole idle periods in a non-negative gap, saturated
   function automatic int zero_run(longint gap);
      longint period;
      longint q;
      period = cfg.idle_period_us;
      if (period == 0) begin
         return MAX_ZEROS;
      end
      q = gap / period;
      return (q > MAX_ZEROS) ? MAX_ZEROS : int'(q);
   endfunction

   // 0 at or below lo, 1 at or below hi, else 2
   function automatic int band(logic [DUR_W-1:0] v, logic [DUR_W-1:0] lo,
                               logic [DUR_W-1:0] hi);
      if (v <= lo) begin
         return 0;
      end else if (v <= hi) begin
         return 1;
      end
      return 2;
   endfunction

   // symbols caused by one accepted flow, then the state moves on
   function automatic void encode_flow(flow_t f);
      longint            start;
      longint            period;
      longint            t1;
      longint            t2;
      longint            hi_gap;
      longint            lo_gap;
      longint unsigned   num;
      longint unsigned   den;
      longint unsigned   ratio;
      logic              t1v;
      logic              t2v;
      logic              has_gap_sym;
      int                zeros;
      int                col;
      per_type           per;
      logic [CHAR_W-1:0] base;
      logic [CHAR_W-1:0] gap_sym;
      symbol_t           s;

      start  = f.start_time_us;
      period = cfg.idle_period_us;
      t1     = last_gap_us;
      t1v    = last_gap_ok;
      t2v    = seen_flow;
      t2     = t2v ? start - longint'(last_start_us) : 0;
      zeros  = 0;
      per    = PER_NONE;

      // zeros and periodicity need both gaps
      if (t1v && t2v) begin
         if (t2 >= 0 && t2 >= period) begin
            zeros = zero_run(t2);
         end else if (t1 >= 0 && t1 >= period) begin
            zeros = zero_run(t1);
         end
         if (t2 >= t1) begin
            hi_gap = t2;
            lo_gap = t1;
         end else begin
            hi_gap = t1;
            lo_gap = t2;
         end
         ratio = 256;
         if (lo_gap > 0) begin
            num   = hi_gap;
            den   = lo_gap;
            ratio = (num << FRAC_W) / den;
         end
         if (ratio <= cfg.ratio_strong) begin
            per = PER_STRONG;
         end else if (ratio < cfg.ratio_weak) begin
            per = PER_WEAK;
         end else if (ratio < cfg.ratio_not_periodic) begin
            per = PER_WEAK_NOT;
         end else begin
            per = PER_NOT;
         end
      end

      // gap length symbol
      has_gap_sym = 1'b0;
      gap_sym     = CHAR_DOT;
      if (t2v) begin
         has_gap_sym = 1'b1;
         if (t2 <= DOT_LIMIT) begin
            gap_sym = CHAR_DOT;
         end else if (t2 <= COMMA_LIMIT) begin
            gap_sym = CHAR_COMMA;
         end else if (t2 <= PLUS_LIMIT) begin
            gap_sym = CHAR_PLUS;
         end else if (t2 <= STAR_LIMIT) begin
            gap_sym = CHAR_STAR;
         end else begin
            has_gap_sym = 1'b0;
         end
      end

      case (per)
         PER_STRONG:   base = CHAR_LC_A;
         PER_WEAK:     base = CHAR_UC_A;
         PER_WEAK_NOT: base = CHAR_LC_R;
         PER_NOT:      base = CHAR_UC_R;
         default:      base = CHAR_ONE;
      endcase
      col = band(f.size_bytes, cfg.size_small_bytes, cfg.size_large_bytes) * 3
          + band(f.duration_us, cfg.dur_short_us, cfg.dur_long_us);

      for (int i = 0; i < zeros; i++) begin
         s = '{CHAR_ZERO, 1'b0};
         expected_symbols.push_back(s);
      end
      s = '{base + CHAR_W'(col), !has_gap_sym};
      expected_symbols.push_back(s);
      if (has_gap_sym) begin
         s = '{gap_sym, 1'b1};
         expected_symbols.push_back(s);
      end

      last_start_us = f.start_time_us;
      seen_flow     = 1'b1;
      last_gap_us   = t2;
      last_gap_ok   = t2v;
   endfunction

   // ---------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------

   function automatic void report_mismatch(string field, logic [7:0] want, logic [7:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS) begin
         $display("%0t mismatch on %s: expected %h, got %h", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : check_symbols
      symbol_t want;
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_symbols.size() == 0) begin
            report_mismatch("unexpected symbol", 8'h00, {1'b0, rsp_ch.symbol_char});
         end else begin
            want = expected_symbols.pop_front();
            if (rsp_ch.symbol_char !== want.symbol_char) begin
               report_mismatch("symbol_char", {1'b0, want.symbol_char},
                               {1'b0, rsp_ch.symbol_char});
            end
            if (rsp_ch.last_symbol !== want.last_symbol) begin
               report_mismatch("last_symbol", {7'd0, want.last_symbol},
                               {7'd0, rsp_ch.last_symbol});
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // result side: random stalls and requested long hold-offs
   // ---------------------------------------------------------------

   initial begin : drive_ready
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   function automatic longint unsigned rand_bits(int width);
      longint unsigned v;
      v = {$urandom, $urandom};
      return v >> (64 - width);
   endfunction

   // random value with a random magnitude
   function automatic longint unsigned rand_span(int width);
      return rand_bits(width) >> $urandom_range(0, width - 1);
   endfunction

   // duration or size, mostly on and around the class limits
   function automatic logic [DUR_W-1:0] pick_value(logic [DUR_W-1:0] lo, logic [DUR_W-1:0] hi);
      logic [DUR_W-1:0] v;
      case ($urandom_range(0, 7))
         0:       v = '0;
         1:       v = lo;
         2:       v = lo + 1'b1;
         3:       v = hi;
         4:       v = hi + 1'b1;
         5:       v = '1;
         default: v = DUR_W'(rand_span(DUR_W));
      endcase
      return v;
   endfunction

   // next flow of a random trace: mostly near-periodic gaps and gaps on the limits
   function automatic flow_t next_flow();
      flow_t           f;
      longint          gap;
      longint          period;
      longint          base;
      longint unsigned k;
      int              kind;
      period = cfg.idle_period_us;
      kind   = $urandom_range(0, 99);
      if (kind < 45 && last_gap_ok && last_gap_us > 0) begin
         case ($urandom_range(0, 2))
            0:       k = $urandom_range(0, 90);
            1:       k = $urandom_range(0, 1100);
            default: k = $urandom_range(1000, 1050);
         endcase
         if ($urandom_range(0, 1) == 1) begin
            gap = last_gap_us + longint'((longint'(last_gap_us) * longint'(k)) >>> FRAC_W);
         end else begin
            gap = (last_gap_us <<< FRAC_W) / (longint'(k) + 256);
         end
      end else if (kind < 70) begin
         case ($urandom_range(0, 5))
            0:       base = DOT_LIMIT;
            1:       base = COMMA_LIMIT;
            2:       base = PLUS_LIMIT;
            3:       base = STAR_LIMIT;
            4:       base = period;
            default: base = 0;
         endcase
         gap = base + longint'($urandom_range(0, 4)) - 2;
      end else if (kind < 82) begin
         gap = longint'(rand_span(40));
      end else if (kind < 90) begin
         gap = period * longint'($urandom_range(0, 70)) + longint'($urandom_range(0, 2)) - 1;
      end else if (kind < 96) begin
         // unsorted flow
         gap = -longint'(rand_span(36));
      end else begin
         gap = longint'(rand_bits(TIME_W)) - longint'(last_start_us);
      end
      f.start_time_us = TIME_W'(longint'(last_start_us) + gap);
      f.duration_us   = pick_value(cfg.dur_short_us, cfg.dur_long_us);
      f.size_bytes    = pick_value(cfg.size_small_bytes, cfg.size_large_bytes);
      return f;
   endfunction

   // one flow transfer; valid stays high for a following flow without gap
   task automatic send_flow(flow_t f);
      logic idled;
      idled = 1'b0;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         if (!idled) begin
            req_ch.valid <= 1'b0;
         end
         idled = 1'b1;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.start_time_us <= f.start_time_us;
      req_ch.duration_us   <= f.duration_us;
      req_ch.size_bytes    <= f.size_bytes;
      do begin
         @(posedge clock);
      end while (req_ch.ready !== 1'b1);
      encode_flow(f);
   endtask

   task automatic send_after(longint gap, logic [DUR_W-1:0] dur, logic [SIZE_W-1:0] bytes);
      flow_t f;
      f.start_time_us = TIME_W'(longint'(last_start_us) + gap);
      f.duration_us   = dur;
      f.size_bytes    = bytes;
      send_flow(f);
   endtask

   task automatic send_random_after(longint gap);
      send_after(gap, pick_value(cfg.dur_short_us, cfg.dur_long_us),
                 pick_value(cfg.size_small_bytes, cfg.size_large_bytes));
   endtask

   task automatic run_flows(int count);
      repeat (count) begin
         send_flow(next_flow());
      end
   endtask

   // stop offering and wait for every outstanding symbol
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (expected_symbols.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // all registers, junk above the width of each narrower register, plus one dropped write
   task automatic apply_config(enc_cfg_t c);
      write_reg(CSR_UNUSED + CSR_IDX_W'($urandom_range(0, 7)), CSR_DATA_W'(rand_bits(48)));
      write_reg(CSR_IDLE_PERIOD, c.idle_period_us);
      write_reg(CSR_RATIO_STRONG, {32'(rand_bits(32)), c.ratio_strong});
      write_reg(CSR_RATIO_WEAK, {32'(rand_bits(32)), c.ratio_weak});
      write_reg(CSR_RATIO_NOTPER, {32'(rand_bits(32)), c.ratio_not_periodic});
      write_reg(CSR_DUR_SHORT, {8'(rand_bits(8)), c.dur_short_us});
      write_reg(CSR_DUR_LONG, {8'(rand_bits(8)), c.dur_long_us});
      write_reg(CSR_SIZE_SMALL, {8'(rand_bits(8)), c.size_small_bytes});
      write_reg(CSR_SIZE_LARGE, {8'(rand_bits(8)), c.size_large_bytes});
      csr_we <= 1'b0;
      @(posedge clock);
      cfg = c;
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // no gap on the first flow, only the current gap on the second
   task automatic test_first_flows();
      send_after(0, '0, '0);
      send_after(1000000, '1, '1);
      send_after(1000000, cfg.dur_short_us, cfg.size_small_bytes);
      settle();
   endtask

   // gap ratios on each periodicity limit, both gap orders
   task automatic test_periodicity();
      longint gaps [7] = '{1050782, 1000000, 1054688, 1000000, 1300782, 1000000, 5000000};
      foreach (gaps[i]) begin
         send_random_after(gaps[i]);
      end
      settle();
   endtask

   // gap symbol limits, zero gap and an unsorted flow
   task automatic test_gap_symbols();
      longint gaps [10] = '{0, 5000000, 5000001, 60000000, 60000001, 300000000,
                            300000001, 3600000000, 3600000001, -7};
      foreach (gaps[i]) begin
         send_random_after(gaps[i]);
      end
      settle();
   endtask

   // saturated zero runs, latest start time, then a jump back to zero
   task automatic test_idle_zeros();
      flow_t f;
      send_random_after(300000000000);
      f = '{'1, pick_value(cfg.dur_short_us, cfg.dur_long_us), '0};
      send_flow(f);
      f = '{'0, '0, pick_value(cfg.size_small_bytes, cfg.size_large_bytes)};
      send_flow(f);
      settle();
   endtask

   task automatic test_reset_limits();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      apply_config(RESET_CFG);
      run_flows(100);
      settle();
   endtask

   // short idle period so that most gaps give zero runs
   task automatic test_short_idle_period();
      enc_cfg_t c;
      c                = RESET_CFG;
      c.idle_period_us = $urandom_range(1000, 5000000);
      send_idle_pct    = 69;
      recv_stall_pct   = 0;
      apply_config(c);
      run_flows(100);
      settle();
   endtask

   task automatic test_random_limits();
      enc_cfg_t c;
      c.idle_period_us     = TIME_W'(rand_span(36)) + 1'b1;
      c.ratio_strong       = $urandom_range(200, 400);
      c.ratio_weak         = $urandom_range(250, 700);
      c.ratio_not_periodic = $urandom_range(300, 2000);
      c.dur_short_us       = DUR_W'(rand_span(30));
      c.dur_long_us        = DUR_W'(rand_span(34));
      c.size_small_bytes   = DUR_W'(rand_span(16));
      c.size_large_bytes   = DUR_W'(rand_span(24));
      send_idle_pct        = 0;
      recv_stall_pct       = 69;
      apply_config(c);
      run_flows(100);
      settle();
   endtask

   // short limit above long limit, small limit above large limit
   task automatic test_crossed_limits();
      enc_cfg_t c;
      c                  = RESET_CFG;
      c.dur_short_us     = 5000000;
      c.dur_long_us      = 200000;
      c.size_small_bytes = 2000;
      c.size_large_bytes = 300;
      send_idle_pct      = 25;
      recv_stall_pct     = 25;
      apply_config(c);
      run_flows(80);
      settle();
   endtask

   task automatic test_max_limits();
      enc_cfg_t c;
      c.idle_period_us     = '1;
      c.ratio_strong       = '1;
      c.ratio_weak         = '1;
      c.ratio_not_periodic = '1;
      c.dur_short_us       = '1;
      c.dur_long_us        = '1;
      c.size_small_bytes   = '1;
      c.size_large_bytes   = '1;
      send_idle_pct        = 0;
      recv_stall_pct       = 0;
      apply_config(c);
      run_flows(40);
      settle();
   endtask

   task automatic test_min_limits();
      enc_cfg_t c;
      c.idle_period_us     = 1;
      c.ratio_strong       = '0;
      c.ratio_weak         = '0;
      c.ratio_not_periodic = '0;
      c.dur_short_us       = '0;
      c.dur_long_us        = '0;
      c.size_small_bytes   = '0;
      c.size_large_bytes   = '0;
      send_idle_pct        = 69;
      recv_stall_pct       = 0;
      apply_config(c);
      run_flows(40);
      settle();
   endtask

   // zero idle period: every non-negative gap gives a full zero run
   task automatic test_zero_idle_period();
      enc_cfg_t c;
      c                = RESET_CFG;
      c.idle_period_us = '0;
      send_idle_pct    = 0;
      recv_stall_pct   = 69;
      apply_config(c);
      run_flows(12);
      settle();
   endtask

   // result side held off while flows keep coming
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      apply_config(RESET_CFG);
      hold_requests++;
      run_flows(30);
      settle();
   endtask

   // one flow at a time, each fully drained before the next
   task automatic test_drain_pause();
      send_idle_pct  = 25;
      recv_stall_pct = 25;
      repeat (10) begin
         send_flow(next_flow());
         settle();
      end
   endtask

   initial begin
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.start_time_us <= '0;
      req_ch.duration_us   <= '0;
      req_ch.size_bytes    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_first_flows();
      test_periodicity();
      test_gap_symbols();
      test_idle_zeros();
      test_reset_limits();
      test_short_idle_period();
      test_random_limits();
      test_crossed_limits();
      test_max_limits();
      test_min_limits();
      test_zero_idle_period();
      test_backpressure();
      test_drain_pause();

      // quiet period to catch stray symbols
      settle();
      repeat (150) @(posedge clock);
      if (error_count == 0) begin
         $display("[flow_behaviour_letter_encoder] OK");
      end else begin
         $display("[flow_behaviour_letter_encoder] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/fble_pkg.sv
rtl/core/fble_req_if.sv
rtl/core/fble_rsp_if.sv
rtl/core/fble_div.sv
rtl/core/flow_behaviour_letter_encoder.sv
tb/flow_behaviour_letter_encoder_tb.sv
